// ===== sv/mf3_pkg.sv =====
// Shared types, constants and the compare-exchange network of the 3x3 median filter.
// Used by median_filter_3x3_top; depends on nothing else.

package mf3_pkg;

   // Pixel and result field widths
   localparam int PIX_W     = 32;
   localparam int COL_OUT_W = 10;
   localparam int ROW_OUT_W = 12;

   // Configuration registers
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam int unsigned RESET_FRAME_WIDTH  = 640;
   localparam int unsigned RESET_FRAME_HEIGHT = 480;
   localparam int unsigned MIN_DIM            = 2;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Item actions
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // Line memory: one word per column, one lane per row slot (row number modulo 4)
   localparam int ROW_SLOTS  = 4;
   localparam int ROW_LANE_W = $clog2(ROW_SLOTS);

   // Window and sorting network
   localparam int WIN_DIM     = 3;
   localparam int WIN_SIZE    = WIN_DIM * WIN_DIM;
   localparam int WIN_IDX_W   = $clog2(WIN_SIZE);
   localparam int WIN_MID     = WIN_SIZE / 2;
   localparam int SORT_STAGES = 9;
   localparam int SORT_IDX_W  = $clog2(SORT_STAGES);
   localparam int SORT_PAIRS  = 3;

   // Result queue
   localparam int OUT_FIFO_DEPTH = 16;

   typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic [COL_OUT_W-1:0] col;
      logic [ROW_OUT_W-1:0] row;
      logic                 frame_end;
   } out_meta_type;

   typedef struct packed {
      logic [PIX_W-1:0] median;
      out_meta_type     meta;
   } out_item_type;

   // Median-of-nine exchange network, one layer per stage. Each pair leaves the
   // smaller word at the first index and the larger at the second.
   localparam logic [WIN_IDX_W-1:0] SORT_LO [SORT_STAGES][SORT_PAIRS] = '{
      '{1, 4, 7}, '{0, 3, 6}, '{1, 4, 7}, '{0, 5, 4}, '{3, 1, 2},
      '{4, 0, 0}, '{4, 0, 0}, '{6, 0, 0}, '{4, 0, 0}
   };
   localparam logic [WIN_IDX_W-1:0] SORT_HI [SORT_STAGES][SORT_PAIRS] = '{
      '{2, 5, 8}, '{1, 4, 7}, '{2, 5, 8}, '{3, 8, 7}, '{6, 4, 5},
      '{7, 0, 0}, '{2, 0, 0}, '{4, 0, 0}, '{2, 0, 0}
   };
   localparam logic [1:0] SORT_CNT [SORT_STAGES] = '{3, 3, 3, 3, 3, 1, 1, 1, 1};

   function automatic win_type sort_layer(input win_type w, input logic [SORT_IDX_W-1:0] stage);
      win_type r;
      r = w;
      for (int i = 0; i < SORT_PAIRS; i++) begin
         if (i < int'(SORT_CNT[stage])) begin
            if ($signed(w[SORT_LO[stage][i]]) > $signed(w[SORT_HI[stage][i]])) begin
               r[SORT_LO[stage][i]] = w[SORT_HI[stage][i]];
               r[SORT_HI[stage][i]] = w[SORT_LO[stage][i]];
            end
         end
      end
      return r;
   endfunction

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      int unsigned r;
      r = v;
      if (v < MIN_DIM) r = MIN_DIM;
      else if (v > hi) r = hi;
      return r;
   endfunction

endpackage

// ===== sv/median_filter_3x3_top.sv =====
// 3x3 median filter over a raster pixel stream, edge-clamped, with line memory and sort pipeline.
// Depends on mf3_pkg.

// One transaction is taken per clock on the request side while req_ready is high, and one result
// per clock leaves on the response side while rsp_ready is high. A result reaches the 16-entry
// output queue once the transaction that releases it has passed the line memory read, the window
// load and the nine compare-exchange layers. req_ready drops only while 16 results are queued or
// in flight, so the queue depth sets how far the consumer may fall behind before input stalls. The
// line memory keeps the four most recent rows as four 32-bit lanes per column; each cycle it takes
// one pixel write, one column read for the window and a read of column 0 for the start of a
// row. Frame sizes are clamped to [2, MAX_WIDTH] and [2, MAX_HEIGHT] and latched at the first
// pixel of a frame. Once a frame's last pixel is in, further pixel transactions count as drains
// until all its outputs are out. The line memory has no clear after reset.
module median_filter_3x3_top #(
   parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [mf3_pkg::PIX_W-1:0]         req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mf3_pkg::PIX_W-1:0]         rsp_median_out,
   output logic [mf3_pkg::COL_OUT_W-1:0]     rsp_out_col,
   output logic [mf3_pkg::ROW_OUT_W-1:0]     rsp_out_row,
   output logic                              rsp_frame_end,
   input  logic                              csr_wr_en,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int DIM_W_W = $clog2(MAX_WIDTH + 1);
   localparam int DIM_H_W = $clog2(MAX_HEIGHT + 1);
   localparam int FIFO_AW = $clog2(mf3_pkg::OUT_FIFO_DEPTH);
   localparam int CNT_W   = FIFO_AW + 1;
   localparam int LAST_STAGE = mf3_pkg::SORT_STAGES - 1;

   localparam logic [DIM_W_W-1:0] RESET_CUR_W =
      DIM_W_W'(mf3_pkg::clamp_dim(mf3_pkg::RESET_FRAME_WIDTH, MAX_WIDTH));
   localparam logic [DIM_H_W-1:0] RESET_CUR_H =
      DIM_H_W'(mf3_pkg::clamp_dim(mf3_pkg::RESET_FRAME_HEIGHT, MAX_HEIGHT));
   localparam logic [CNT_W-1:0] FIFO_FULL = CNT_W'(mf3_pkg::OUT_FIFO_DEPTH);

   // ---------------------------------------------------------------- registers
   logic [mf3_pkg::CFG_W_W-1:0] frame_width_ff;
   logic [mf3_pkg::CFG_H_W-1:0] frame_height_ff;
   logic [DIM_W_W-1:0]          cur_w_ff;
   logic [DIM_H_W-1:0]          cur_h_ff;
   logic [COL_W-1:0]            in_col_ff, emit_col_ff;
   logic [ROW_W-1:0]            in_row_ff, emit_row_ff;
   logic                        frame_in_ff;

   logic [COL_W-1:0]            in_col_in, emit_col_in;
   logic [ROW_W-1:0]            in_row_in, emit_row_in;
   logic                        frame_in_in;

   logic [mf3_pkg::ROW_SLOTS-1:0][mf3_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];

   logic [mf3_pkg::ROW_SLOTS-1:0][mf3_pkg::PIX_W-1:0] rd_a_ff, rd_b_ff;
   logic                                              fwd_a_ff, fwd_b_ff;
   logic [mf3_pkg::ROW_LANE_W-1:0]                    fwd_lane_ff;
   logic [mf3_pkg::PIX_W-1:0]                         fwd_data_ff;

   logic                                              s1_valid_ff, s1_zero_ff;
   logic [mf3_pkg::WIN_DIM-1:0][mf3_pkg::ROW_LANE_W-1:0] s1_lane_ff;
   mf3_pkg::out_meta_type                             s1_meta_ff;

   mf3_pkg::win_type                                  win_ff;
   logic                                              win_vld_ff;
   mf3_pkg::out_meta_type                             win_meta_ff;

   mf3_pkg::win_type                                  srt_ff [mf3_pkg::SORT_STAGES];
   logic                                              srt_vld_ff [mf3_pkg::SORT_STAGES];
   mf3_pkg::out_meta_type                             srt_meta_ff [mf3_pkg::SORT_STAGES];

   mf3_pkg::out_item_type                             fifo_mem_ff [mf3_pkg::OUT_FIFO_DEPTH];
   logic [FIFO_AW-1:0]                                wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]                                  fifo_cnt_ff, occ_ff;
   logic [CNT_W-1:0]                                  fifo_cnt_in, occ_in;

   // ---------------------------------------------------------------- item control
   logic                  accept, pix_item, first_pix, emit, frame_end;
   logic [DIM_W_W-1:0]    cfg_w_clamp, w_use, w_last;
   logic [DIM_H_W-1:0]    cfg_h_clamp, h_use, h_last;
   logic                  in_col_last, in_row_last, ec_last, er_last;
   logic [COL_W-1:0]      nc;
   logic [ROW_W-1:0]      nr, rm;
   logic                  frame_in_mid;
   logic                  push, pop;

   assign req_ready = occ_ff < FIFO_FULL;
   assign accept    = req_valid && req_ready;
   assign pix_item  = (req_action == mf3_pkg::ACTION_PIXEL) && !frame_in_ff;
   assign first_pix = pix_item && (in_col_ff == '0) && (in_row_ff == '0);

   always_comb begin
      if (32'(frame_width_ff) < mf3_pkg::MIN_DIM) cfg_w_clamp = DIM_W_W'(mf3_pkg::MIN_DIM);
      else if (32'(frame_width_ff) > MAX_WIDTH)   cfg_w_clamp = DIM_W_W'(MAX_WIDTH);
      else                                        cfg_w_clamp = DIM_W_W'(frame_width_ff);
      if (32'(frame_height_ff) < mf3_pkg::MIN_DIM) cfg_h_clamp = DIM_H_W'(mf3_pkg::MIN_DIM);
      else if (32'(frame_height_ff) > MAX_HEIGHT)  cfg_h_clamp = DIM_H_W'(MAX_HEIGHT);
      else                                         cfg_h_clamp = DIM_H_W'(frame_height_ff);
   end

   assign w_use  = first_pix ? cfg_w_clamp : cur_w_ff;
   assign h_use  = first_pix ? cfg_h_clamp : cur_h_ff;
   assign w_last = w_use - DIM_W_W'(1);
   assign h_last = h_use - DIM_H_W'(1);

   assign in_col_last = DIM_W_W'(in_col_ff) == w_last;
   assign in_row_last = DIM_H_W'(in_row_ff) == h_last;
   assign ec_last     = DIM_W_W'(emit_col_ff) == w_last;
   assign er_last     = DIM_H_W'(emit_row_ff) == h_last;

   // Advance the input position
   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      frame_in_mid = frame_in_ff;
      if (pix_item) begin
         if (in_col_last) begin
            in_col_in = '0;
            if (in_row_last) begin
               in_row_in    = '0;
               frame_in_mid = 1'b1;
            end else begin
               in_row_in = in_row_ff + ROW_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
   end

   // Clamped neighbours of the next output; (nr, nc) is also the last pixel it needs
   assign nc = ec_last ? emit_col_ff : emit_col_ff + COL_W'(1);
   assign nr = er_last ? emit_row_ff : emit_row_ff + ROW_W'(1);
   assign rm = (emit_row_ff == '0) ? emit_row_ff : emit_row_ff - ROW_W'(1);

   assign emit = frame_in_mid || (nr < in_row_in) || ((nr == in_row_in) && (nc < in_col_in));
   assign frame_end = er_last && ec_last;

   always_comb begin
      emit_col_in = emit_col_ff;
      emit_row_in = emit_row_ff;
      frame_in_in = frame_in_mid;
      if (emit) begin
         if (frame_end) begin
            emit_col_in = '0;
            emit_row_in = '0;
            frame_in_in = 1'b0;
         end else if (ec_last) begin
            emit_col_in = '0;
            emit_row_in = emit_row_ff + ROW_W'(1);
         end else begin
            emit_col_in = emit_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mf3_pkg::CFG_W_W'(mf3_pkg::RESET_FRAME_WIDTH);
         frame_height_ff <= mf3_pkg::CFG_H_W'(mf3_pkg::RESET_FRAME_HEIGHT);
         cur_w_ff        <= RESET_CUR_W;
         cur_h_ff        <= RESET_CUR_H;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         emit_col_ff     <= '0;
         emit_row_ff     <= '0;
         frame_in_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mf3_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[mf3_pkg::CFG_W_W-1:0];
               mf3_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[mf3_pkg::CFG_H_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            if (first_pix) begin
               cur_w_ff <= cfg_w_clamp;
               cur_h_ff <= cfg_h_clamp;
            end
            in_col_ff   <= in_col_in;
            in_row_ff   <= in_row_in;
            emit_col_ff <= emit_col_in;
            emit_row_ff <= emit_row_in;
            frame_in_ff <= frame_in_in;
         end
      end
   end

   // ---------------------------------------------------------------- line memory
   logic wr_en;
   assign wr_en = accept && pix_item;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[in_col_ff][mf3_pkg::ROW_LANE_W'(in_row_ff)] <= req_pixel_in;
      end
      rd_a_ff <= line_mem[nc];
      rd_b_ff <= line_mem[0];
   end

   // A write in the same cycle as the read is not seen by it: forward that lane
   always_ff @(posedge clock) begin
      fwd_a_ff    <= wr_en && (in_col_ff == nc);
      fwd_b_ff    <= wr_en && (in_col_ff == '0);
      fwd_lane_ff <= mf3_pkg::ROW_LANE_W'(in_row_ff);
      fwd_data_ff <= req_pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && emit;
      end
      s1_zero_ff           <= emit_col_ff == '0;
      s1_lane_ff[0]        <= mf3_pkg::ROW_LANE_W'(rm);
      s1_lane_ff[1]        <= mf3_pkg::ROW_LANE_W'(emit_row_ff);
      s1_lane_ff[2]        <= mf3_pkg::ROW_LANE_W'(nr);
      s1_meta_ff.col       <= mf3_pkg::COL_OUT_W'(emit_col_ff);
      s1_meta_ff.row       <= mf3_pkg::ROW_OUT_W'(emit_row_ff);
      s1_meta_ff.frame_end <= frame_end;
   end

   // ---------------------------------------------------------------- window
   logic [mf3_pkg::ROW_SLOTS-1:0][mf3_pkg::PIX_W-1:0] col_a, col_b;
   logic [mf3_pkg::WIN_DIM-1:0][mf3_pkg::PIX_W-1:0]   new_a, new_b;

   always_comb begin
      col_a = rd_a_ff;
      col_b = rd_b_ff;
      if (fwd_a_ff) col_a[fwd_lane_ff] = fwd_data_ff;
      if (fwd_b_ff) col_b[fwd_lane_ff] = fwd_data_ff;
      for (int r = 0; r < mf3_pkg::WIN_DIM; r++) begin
         new_a[r] = col_a[s1_lane_ff[r]];
         new_b[r] = col_b[s1_lane_ff[r]];
      end
   end

   // Slide one column per output; at the start of a row load column 0 twice and column 1
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         win_vld_ff <= 1'b0;
      end else begin
         win_vld_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            for (int r = 0; r < mf3_pkg::WIN_DIM; r++) begin
               if (s1_zero_ff) begin
                  win_ff[mf3_pkg::WIN_DIM*r]     <= new_b[r];
                  win_ff[mf3_pkg::WIN_DIM*r + 1] <= new_b[r];
               end else begin
                  win_ff[mf3_pkg::WIN_DIM*r]     <= win_ff[mf3_pkg::WIN_DIM*r + 1];
                  win_ff[mf3_pkg::WIN_DIM*r + 1] <= win_ff[mf3_pkg::WIN_DIM*r + 2];
               end
               win_ff[mf3_pkg::WIN_DIM*r + 2] <= new_a[r];
            end
         end
      end
      win_meta_ff <= s1_meta_ff;
   end

   // ---------------------------------------------------------------- sort pipeline
   always_ff @(posedge clock) begin
      for (int k = 0; k < mf3_pkg::SORT_STAGES; k++) begin
         if (k == 0) begin
            srt_ff[k]      <= mf3_pkg::sort_layer(win_ff, mf3_pkg::SORT_IDX_W'(k));
            srt_meta_ff[k] <= win_meta_ff;
         end else begin
            srt_ff[k]      <= mf3_pkg::sort_layer(srt_ff[k-1], mf3_pkg::SORT_IDX_W'(k));
            srt_meta_ff[k] <= srt_meta_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < mf3_pkg::SORT_STAGES; k++) begin
         if (reset) srt_vld_ff[k] <= 1'b0;
         else if (k == 0) srt_vld_ff[k] <= win_vld_ff;
         else srt_vld_ff[k] <= srt_vld_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- output queue
   assign push = srt_vld_ff[LAST_STAGE];
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      occ_in      = occ_ff;
      if (push) fifo_cnt_in = fifo_cnt_in + CNT_W'(1);
      if (pop) begin
         fifo_cnt_in = fifo_cnt_in - CNT_W'(1);
         occ_in      = occ_in - CNT_W'(1);
      end
      // Hold a slot for every result from the moment its transaction is taken
      if (accept && emit) occ_in = occ_in + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         occ_ff      <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         fifo_cnt_ff <= fifo_cnt_in;
         occ_ff      <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff].median <= srt_ff[LAST_STAGE][mf3_pkg::WIN_MID];
         fifo_mem_ff[wr_ptr_ff].meta   <= srt_meta_ff[LAST_STAGE];
      end
   end

   assign rsp_valid      = fifo_cnt_ff != '0;
   assign rsp_median_out = fifo_mem_ff[rd_ptr_ff].median;
   assign rsp_out_col    = fifo_mem_ff[rd_ptr_ff].meta.col;
   assign rsp_out_row    = fifo_mem_ff[rd_ptr_ff].meta.row;
   assign rsp_frame_end  = fifo_mem_ff[rd_ptr_ff].meta.frame_end;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ((fifo_cnt_ff != FIFO_FULL) || pop))
      else $error("result queue written while full");

   a_credit_covers_queue: assert property (@(posedge clock) disable iff (reset)
      occ_ff >= fifo_cnt_ff)
      else $error("slot count below queue fill");

   a_emit_behind_input: assert property (@(posedge clock) disable iff (reset)
      !frame_in_ff |-> ((emit_row_ff < in_row_ff) ||
                        ((emit_row_ff == in_row_ff) && (emit_col_ff <= in_col_ff))))
      else $error("output position ahead of input position");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for median_filter_3x3_top: a directed table, then random frames.
// Predicts each median from its own line store and window sort; needs mf3_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
   import mf3_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   localparam int QUIET_CYCLES = 32;
   localparam int HOLD_CYCLES  = 400;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int PHASE_ITEMS  = 250;
   localparam int MAX_PRINTS   = 50;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CSR} row_kind_e;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} check_e;

   typedef struct packed {
      row_kind_e                 kind;
      logic                      act;
      logic [CSR_IDX_W-1:0]      idx;
      logic [PIX_W-1:0]          data;
      check_e                    chk;
      logic [PIX_W-1:0]          e_med;
      logic [COL_OUT_W-1:0]      e_col;
      logic [ROW_OUT_W-1:0]      e_row;
      logic                      e_end;
   } dir_row_t;

   // Idle drain after reset, a flat 2x2 frame at the signed minimum with a dropped pixel,
   // a 2x2 frame of sign extremes, then a 3x2 frame with both sizes rewritten mid-frame.
   localparam dir_row_t DIRECTED [31] = '{
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_NONE, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_CSR, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'd1, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_CSR, ACTION_PIXEL, CSR_FRAME_HEIGHT, 32'd0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h80000000, CHK_NONE,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h80000000, CHK_NONE,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h80000000, CHK_NONE,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h80000000, CHK_GIVEN,
        32'h80000000, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h12345678, CHK_GIVEN,
        32'h80000000, 10'd1, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_GIVEN,
        32'h80000000, 10'd0, 12'd1, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_GIVEN,
        32'h80000000, 10'd1, 12'd1, 1'b1},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h7FFFFFFF, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'hFFFFFFFF, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h00000000, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h80000000, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_CSR, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'd3, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_CSR, ACTION_PIXEL, CSR_FRAME_HEIGHT, 32'd1, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'hFFFFFFFE, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h00000001, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_CSR, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'd2047, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_CSR, ACTION_PIXEL, CSR_FRAME_HEIGHT, 32'd8191, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h7FFFFFFE, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h80000001, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'h0000FFFF, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_PIXEL, CSR_FRAME_WIDTH, 32'hFFFF0000, CHK_MODEL,
        32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0},
      '{ROW_ITEM, ACTION_DRAIN, CSR_FRAME_WIDTH, 32'h0, CHK_MODEL, 32'h0, 10'd0, 12'd0, 1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_action;
   logic [PIX_W-1:0]      req_pixel_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIX_W-1:0]      rsp_median_out;
   logic [COL_OUT_W-1:0]  rsp_out_col;
   logic [ROW_OUT_W-1:0]  rsp_out_row;
   logic                  rsp_frame_end;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor state
   logic [PIX_W-1:0]   line_mem [ROW_SLOTS][DEF_MAX_WIDTH];
   logic [CFG_W_W-1:0] width_reg;
   logic [CFG_H_W-1:0] height_reg;
   int                 in_col, in_row, emit_col, emit_row, lat_w, lat_h;
   bit                 frame_loaded;

   out_item_type median_q [$];
   out_item_type want;

   int src_idle_pct, sink_idle_pct;
   bit hold_off_req, next_size_set;
   int fail_count, checked_count, pixel_count, drain_count, frame_count, cycle_count;

   median_filter_3x3_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_median_out(rsp_median_out),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic int fit_dim(input int v, input int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   // Rank as signed words and take the middle one
   function automatic logic [PIX_W-1:0] median_of_nine(input logic [8:0][PIX_W-1:0] w);
      logic [PIX_W-1:0] key;
      int j;
      for (int i = 1; i < 9; i++) begin
         key = w[i];
         j = i - 1;
         while (j >= 0 && $signed(w[j]) > $signed(key)) begin
            w[j + 1] = w[j];
            j--;
         end
         w[j + 1] = key;
      end
      return w[4];
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] p;
      case ($urandom_range(3))
         0, 1: p = $urandom;
         2: begin
            case ($urandom_range(5))
               0:       p = 32'h00000000;
               1:       p = 32'h7FFFFFFF;
               2:       p = 32'h80000000;
               3:       p = 32'hFFFFFFFF;
               4:       p = 32'h00000001;
               default: p = 32'h80000001;
            endcase
         end
         // values just above zero or just above the signed minimum give plenty of ties
         default: p = {1'($urandom_range(1)), 28'h0, 3'($urandom_range(7))};
      endcase
      return p;
   endfunction

   task automatic filter_step(input logic act, input logic [PIX_W-1:0] pix,
                              output bit has, output out_item_type res);
      logic [8:0][PIX_W-1:0] win;
      int arrived, need_r, need_c, k, rr, cc;
      bit last;
      has = 1'b0;
      res = '0;
      if (act == ACTION_PIXEL && !frame_loaded) begin
         if (in_col == 0 && in_row == 0) begin
            lat_w = fit_dim(int'(width_reg), DEF_MAX_WIDTH);
            lat_h = fit_dim(int'(height_reg), DEF_MAX_HEIGHT);
         end
         line_mem[in_row % ROW_SLOTS][in_col] = pix;
         if (in_col == lat_w - 1) begin
            in_col = 0;
            if (in_row == lat_h - 1) begin
               in_row = 0;
               frame_loaded = 1'b1;
            end else begin
               in_row++;
            end
         end else begin
            in_col++;
         end
      end
      arrived = frame_loaded ? lat_w * lat_h : in_row * lat_w + in_col;
      need_r = (emit_row + 1 < lat_h) ? emit_row + 1 : lat_h - 1;
      need_c = (emit_col + 1 < lat_w) ? emit_col + 1 : lat_w - 1;
      if (need_r * lat_w + need_c >= arrived) return;
      k = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         rr = emit_row + dr;
         if (rr < 0) rr = 0;
         else if (rr >= lat_h) rr = lat_h - 1;
         for (int dc = -1; dc <= 1; dc++) begin
            cc = emit_col + dc;
            if (cc < 0) cc = 0;
            else if (cc >= lat_w) cc = lat_w - 1;
            win[k] = line_mem[rr % ROW_SLOTS][cc];
            k++;
         end
      end
      last = (emit_row == lat_h - 1) && (emit_col == lat_w - 1);
      has = 1'b1;
      res.median = median_of_nine(win);
      res.meta.col = COL_OUT_W'(emit_col);
      res.meta.row = ROW_OUT_W'(emit_row);
      res.meta.frame_end = last;
      if (last) begin
         emit_col = 0;
         emit_row = 0;
         frame_loaded = 1'b0;
      end else if (emit_col == lat_w - 1) begin
         emit_col = 0;
         emit_row++;
      end else begin
         emit_col++;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [PIX_W-1:0] got,
                                  input logic [PIX_W-1:0] exp_val);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("mismatch on %s at cycle %0d: got %h, expected %h",
                  field, cycle_count, got, exp_val);
   endtask

   // Offer one transaction, hold it until taken, then predict its result
   task automatic push_item(input logic act, input logic [PIX_W-1:0] pix, input bit typed,
                            input bit typed_has, input out_item_type typed_res);
      bit has;
      out_item_type res;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      if (act == ACTION_PIXEL && !frame_loaded) pixel_count++;
      else drain_count++;
      filter_step(act, pix, has, res);
      if (typed) begin
         has = typed_has;
         res = typed_res;
      end
      if (has) median_q.push_back(res);
      @(negedge clock);
   endtask

   // Stop offering until every pending median is out, then let the pipeline settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (median_q.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) width_reg = val[CFG_W_W-1:0];
      else height_reg = val;
      @(negedge clock);
   endtask

   task automatic program_sizes();
      logic [CSR_DATA_W-1:0] wv, hv;
      wv = ($urandom_range(9) == 0) ? CSR_DATA_W'($urandom_range(1)) :
                                      CSR_DATA_W'($urandom_range(12, 2));
      // upper bits beyond the width register are dropped
      if ($urandom_range(4) == 0) wv[CSR_DATA_W-1:CFG_W_W] = 2'($urandom_range(3));
      hv = ($urandom_range(9) == 0) ? CSR_DATA_W'($urandom_range(1)) :
                                      CSR_DATA_W'($urandom_range(9, 2));
      csr_write(CSR_FRAME_WIDTH, wv);
      csr_write(CSR_FRAME_HEIGHT, hv);
   endtask

   // One whole frame with drain noise, an optional mid-frame pause and optional output hold-off
   task automatic run_frame(input int hold_at, output int n_items);
      int total, pause_at, start;
      start = pixel_count + drain_count;
      total = fit_dim(int'(width_reg), DEF_MAX_WIDTH) * fit_dim(int'(height_reg), DEF_MAX_HEIGHT);
      pause_at = ($urandom_range(99) < 35) ? $urandom_range(total - 1, 1) : -1;
      for (int k = 0; k < total; k++) begin
         if (k == hold_at) hold_off_req = 1'b1;
         if (k == pause_at) begin
            wait_quiet();
            // sizes written now only apply to the next frame
            if ($urandom_range(1)) begin
               program_sizes();
               next_size_set = 1'b1;
            end
         end
         if ($urandom_range(99) < 8) push_item(ACTION_DRAIN, $urandom, 1'b0, 1'b0, '0);
         push_item(ACTION_PIXEL, rand_pixel(), 1'b0, 1'b0, '0);
      end
      while (frame_loaded) begin
         push_item(($urandom_range(99) < 20) ? ACTION_PIXEL : ACTION_DRAIN, $urandom,
                   1'b0, 1'b0, '0);
      end
      repeat ($urandom_range(2)) push_item(ACTION_DRAIN, $urandom, 1'b0, 1'b0, '0);
      frame_count++;
      n_items = pixel_count + drain_count - start;
   endtask

   // Receiver: random stalls, or a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (median_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_median_out, '0);
         end else begin
            want = median_q.pop_front();
            checked_count++;
            if (rsp_median_out !== want.median)
               report_mismatch("median", rsp_median_out, want.median);
            if (rsp_out_col !== want.meta.col)
               report_mismatch("column", PIX_W'(rsp_out_col), PIX_W'(want.meta.col));
            if (rsp_out_row !== want.meta.row)
               report_mismatch("row", PIX_W'(rsp_out_row), PIX_W'(want.meta.row));
            if (rsp_frame_end !== want.meta.frame_end)
               report_mismatch("frame end", PIX_W'(rsp_frame_end), PIX_W'(want.meta.frame_end));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("run stopped at the cycle limit with %0d medians pending", median_q.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      out_item_type given;
      int n, phase_items;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = ACTION_PIXEL;
      req_pixel_in = '0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_FRAME_WIDTH;
      csr_wdata    = '0;
      hold_off_req = 1'b0;
      next_size_set = 1'b0;
      width_reg    = CFG_W_W'(RESET_FRAME_WIDTH);
      height_reg   = CFG_H_W'(RESET_FRAME_HEIGHT);
      in_col = 0; in_row = 0; emit_col = 0; emit_row = 0;
      lat_w = fit_dim(int'(width_reg), DEF_MAX_WIDTH);
      lat_h = fit_dim(int'(height_reg), DEF_MAX_HEIGHT);
      frame_loaded = 1'b0;
      src_idle_pct = 37;
      sink_idle_pct = 82;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            wait_quiet();
            csr_write(DIRECTED[i].idx, DIRECTED[i].data[CSR_DATA_W-1:0]);
         end else begin
            given.median = DIRECTED[i].e_med;
            given.meta.col = DIRECTED[i].e_col;
            given.meta.row = DIRECTED[i].e_row;
            given.meta.frame_end = DIRECTED[i].e_end;
            push_item(DIRECTED[i].act, DIRECTED[i].data, DIRECTED[i].chk != CHK_MODEL,
                      DIRECTED[i].chk == CHK_GIVEN, given);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin src_idle_pct = 37; sink_idle_pct = 82; end
            1: begin src_idle_pct = 82; sink_idle_pct = 37; end
            default: begin src_idle_pct = 0; sink_idle_pct = 0; end
         endcase
         // widest frame while the receiver is slow, tallest one with no idling
         if (ph != 1) begin
            wait_quiet();
            csr_write(CSR_FRAME_WIDTH, (ph == 0) ? CSR_DATA_W'(2047) : CSR_DATA_W'(2));
            csr_write(CSR_FRAME_HEIGHT, (ph == 0) ? CSR_DATA_W'(1) : CSR_DATA_W'(8191));
            next_size_set = 1'b0;
            run_frame((ph == 0) ? 1100 : 100, n);
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if (!next_size_set) begin
               wait_quiet();
               program_sizes();
            end
            next_size_set = 1'b0;
            run_frame(-1, n);
            phase_items += n;
         end
      end

      req_valid <= 1'b0;
      while (median_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);

      $display("%0d pixel and %0d drain transactions over %0d frames, %0d medians checked",
               pixel_count, drain_count, frame_count, checked_count);
      $display("frames from 2x2 to 1024 wide and 4096 tall, with stalls on both sides");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
